### hdl/ttts_pkg.sv
// Package for the time-triggered task scheduler.
// Sizes, action and result codes, and the structs between top level and slot cells.
// No dependencies.
package ttts_pkg;

    localparam int NUM_SLOTS   = 10;
    localparam int MAX_RESULTS = 10;
    localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_DISP  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [1:0] KIND_ADD_FULL = 2'd1;
    localparam logic [1:0] KIND_RUN      = 2'd2;
    localparam logic [1:0] KIND_IDLE     = 2'd3;

    typedef struct packed {
        logic        tick;
        logic        clear;
        logic        add;
        logic        disp;
        logic        kill;
        logic [7:0]  tag;
        logic [15:0] period;
        logic [15:0] first_cd;
    } t_cell_ctl;

    typedef struct packed {
        logic       hit;
        logic       want;
        logic [7:0] tag;
    } t_cell_stat;

endpackage

### hdl/ttts_cell.sv
// One task slot of the scheduler chain: in-use mark, period, countdown, pending runs, tag.
// Passes the walk token to its neighbour every cycle, unless the top level kills the walk.
// Depends on ttts_pkg.
module ttts_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ttts_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_tok,
    output logic                  o_tok,
    output ttts_pkg::t_cell_stat  o_stat
);

    logic        r_tok, n_tok;
    logic        r_used, n_used;
    logic [15:0] r_period, n_period;
    logic [15:0] r_cd, n_cd;
    logic [15:0] r_pend, n_pend;
    logic [7:0]  r_tag, n_tag;
    logic        want;
    logic        hit;

    assign want = r_used & (r_pend != 16'd0);
    assign hit  = r_tok & ((i_ctl.add & ~r_used) | (i_ctl.disp & want));

    always_comb begin
        n_tok    = i_tok & ~i_ctl.kill;
        n_used   = r_used;
        n_period = r_period;
        n_cd     = r_cd;
        n_pend   = r_pend;
        n_tag    = r_tag;
        if (i_ctl.clear) begin
            n_used = 1'b0;
        end else if (i_ctl.tick && r_used) begin
            if (r_cd == 16'd0) begin
                if (r_pend != 16'hFFFF) begin
                    n_pend = r_pend + 16'd1;
                end
                n_cd = r_period;
            end else begin
                n_cd = r_cd - 16'd1;
            end
        end else if (hit && i_ctl.add) begin
            n_used   = 1'b1;
            n_period = i_ctl.period;
            n_cd     = i_ctl.first_cd;
            n_pend   = 16'd0;
            n_tag    = i_ctl.tag;
        end else if (hit) begin
            n_pend = r_pend - 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_used <= 1'b0;
        end else begin
            r_tok  <= n_tok;
            r_used <= n_used;
        end
        r_period <= n_period;
        r_cd     <= n_cd;
        r_pend   <= n_pend;
        r_tag    <= n_tag;
    end

    assign o_tok       = r_tok;
    assign o_stat.hit  = hit;
    assign o_stat.want = want;
    assign o_stat.tag  = r_tag & {8{hit}};

endmodule

### hdl/time_triggered_task_scheduler.sv
// Top level of the time-triggered task scheduler: command port, walk control, result register.
// Depends on ttts_pkg and ttts_cell.
//
// Channel   Direction  Handshake             Payload
// command   in         start & !busy         i_action, i_task_tag, i_task_period, i_start_delay
// result    out        o_strobe (one cycle)  o_kind, o_slot, o_run_tag, o_last
//
// Tick and clear complete in the accept cycle, busy stays low, no result.
// Add and dispatch send a token down the chain of slot cells, one cell per cycle: add ends
// at the first free slot (add-full at the last slot if none), dispatch at the last pending
// slot or the MAX_RESULTS-th run (idle at the last slot if none is pending). Results are
// registered and appear in the cycle after their cell; busy drops with the final result.
// Synchronous active-low reset empties the table; the receiver cannot stall.
module time_triggered_task_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_task_tag,
    input  logic [15:0] i_task_period,
    input  logic [15:0] i_start_delay,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic [7:0]  o_run_tag,
    output logic        o_last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                        r_state, n_state;
    logic [1:0]                  r_op, n_op;
    logic [ttts_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [ttts_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [7:0]                  r_tag_in, n_tag_in;
    logic [15:0]                 r_period_in, n_period_in;
    logic [15:0]                 r_first_cd, n_first_cd;
    logic                        r_strobe, n_strobe;
    logic [1:0]                  r_kind, n_kind;
    logic [3:0]                  r_slot, n_slot;
    logic [7:0]                  r_run_tag, n_run_tag;
    logic                        r_last, n_last;

    logic                        acc;
    logic                        inject;
    logic                        kill;
    ttts_pkg::t_cell_ctl         ctl;
    ttts_pkg::t_cell_stat        stat [ttts_pkg::NUM_SLOTS];
    logic [ttts_pkg::NUM_SLOTS-1:0] tok_vec;
    logic [ttts_pkg::NUM_SLOTS-1:0] hit_vec;
    logic                        any_hit;
    logic [7:0]                  hit_tag;
    logic                        more;
    logic                        at_end;
    logic                        cap;

    assign busy   = (r_state == ST_WALK);
    assign acc    = start & ~busy;
    assign inject = acc & ((i_action == ttts_pkg::ACT_ADD) || (i_action == ttts_pkg::ACT_DISP));
    assign at_end = (r_idx == ttts_pkg::IDX_W'(ttts_pkg::NUM_SLOTS - 1));
    assign cap    = (r_cnt == ttts_pkg::CNT_W'(ttts_pkg::MAX_RESULTS - 1));

    always_comb begin
        any_hit = 1'b0;
        hit_tag = 8'd0;
        more    = 1'b0;
        for (int j = 0; j < ttts_pkg::NUM_SLOTS; j++) begin
            hit_vec[j] = stat[j].hit;
            any_hit    = any_hit | stat[j].hit;
            hit_tag    = hit_tag | stat[j].tag;
            if (ttts_pkg::IDX_W'(j) > r_idx) begin
                more = more | stat[j].want;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_tag_in    = r_tag_in;
        n_period_in = r_period_in;
        n_first_cd  = r_first_cd;
        n_strobe    = 1'b0;
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_run_tag   = r_run_tag;
        n_last      = r_last;
        kill        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (inject) begin
                    n_state     = ST_WALK;
                    n_op        = i_action;
                    n_idx       = '0;
                    n_cnt       = '0;
                    n_tag_in    = i_task_tag;
                    n_period_in = i_task_period;
                    n_first_cd  = (i_start_delay > i_task_period) ? 16'd0
                                                                  : i_task_period - i_start_delay;
                end
            end
            ST_WALK: begin
                n_idx = r_idx + ttts_pkg::IDX_W'(1);
                if (r_op == ttts_pkg::ACT_ADD) begin
                    if (any_hit) begin
                        n_strobe  = 1'b1;
                        n_kind    = ttts_pkg::KIND_ADD_OK;
                        n_slot    = 4'(r_idx);
                        n_run_tag = 8'd0;
                        n_last    = 1'b1;
                        kill      = 1'b1;
                        n_state   = ST_IDLE;
                    end else if (at_end) begin
                        n_strobe  = 1'b1;
                        n_kind    = ttts_pkg::KIND_ADD_FULL;
                        n_slot    = 4'd0;
                        n_run_tag = 8'd0;
                        n_last    = 1'b1;
                        kill      = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end else begin
                    if (any_hit) begin
                        n_strobe  = 1'b1;
                        n_kind    = ttts_pkg::KIND_RUN;
                        n_slot    = 4'(r_idx);
                        n_run_tag = hit_tag;
                        n_last    = ~more | cap;
                        n_cnt     = r_cnt + ttts_pkg::CNT_W'(1);
                        if (~more | cap) begin
                            kill    = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end else if (at_end) begin
                        // nothing was pending anywhere
                        n_strobe  = 1'b1;
                        n_kind    = ttts_pkg::KIND_IDLE;
                        n_slot    = 4'd0;
                        n_run_tag = 8'd0;
                        n_last    = 1'b1;
                        kill      = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl.tick     = acc & (i_action == ttts_pkg::ACT_TICK);
        ctl.clear    = acc & (i_action == ttts_pkg::ACT_CLEAR);
        ctl.add      = busy & (r_op == ttts_pkg::ACT_ADD);
        ctl.disp     = busy & (r_op == ttts_pkg::ACT_DISP);
        ctl.kill     = kill;
        ctl.tag      = r_tag_in;
        ctl.period   = r_period_in;
        ctl.first_cd = r_first_cd;
    end

    for (genvar g = 0; g < ttts_pkg::NUM_SLOTS; g++) begin : g_slot
        logic tok_in;
        if (g == 0) begin : g_head
            assign tok_in = inject;
        end else begin : g_link
            assign tok_in = tok_vec[g-1];
        end
        ttts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_tok   (tok_in),
            .o_tok   (tok_vec[g]),
            .o_stat  (stat[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= ttts_pkg::ACT_TICK;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_strobe <= n_strobe;
        end
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_tag_in    <= n_tag_in;
        r_period_in <= n_period_in;
        r_first_cd  <= n_first_cd;
        r_kind      <= n_kind;
        r_slot      <= n_slot;
        r_run_tag   <= n_run_tag;
        r_last      <= n_last;
    end

    assign o_strobe  = r_strobe;
    assign o_kind    = r_kind;
    assign o_slot    = r_slot;
    assign o_run_tag = r_run_tag;
    assign o_last    = r_last;

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("busy still high with final result");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one walk token in the chain");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec))
        else $error("more than one slot cell hit");

    a_single_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind != ttts_pkg::KIND_RUN)) |-> o_last)
        else $error("single result without final mark");

endmodule
